FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define AST_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gblur_pkg.sv
package gblur_pkg;

   localparam int PIX_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int WGT_W      = 17;
   localparam int WGT_N      = 4;
   localparam int RAD_W      = 3;
   localparam int COL_W      = 12;
   localparam int SLOT_W     = 4;
   localparam int ACC_W      = 29;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_W_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_W_OFF1   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_W_OFF2   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_W_OFF3   = 3'd6;

   typedef logic [WGT_N-1:0][WGT_W-1:0] weights_type;

   // one classified word, handed from the front to the back
   typedef struct packed {
      logic              pass;
      logic              zero_in;
      logic              have_q;
      logic              h_int;
      logic              emit;
      logic              v_int;
      logic              last;
      logic [RAD_W-1:0]  radius;
      logic [SLOT_W-1:0] wr_slot;
      logic [COL_W-1:0]  wr_x;
      logic [SLOT_W-1:0] rd_slot;
      logic [COL_W-1:0]  rd_x;
      logic [PIX_W-1:0]  pix;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_HORZ,
      B_READ,
      B_VERT,
      B_DONE
   } back_state_type;

   function automatic logic [7:0] sat8(input logic [ACC_W-1:0] v);
      logic [7:0] res;
      if (v[ACC_W-1:24] != '0) res = 8'hFF;
      else res = v[23:16];
      return res;
   endfunction

endpackage

FILE: rtl/gblur_ram.sv
module gblur_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 6144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/gblur_queue.sv
module gblur_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      if (pop) rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      if (push && !pop) count_in = count_ff + CW'(1);
      else if (!push && pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full     = (32'(count_ff) == DEPTH);
   assign empty    = (count_ff == '0);
endmodule

FILE: rtl/gblur_front.sv
module gblur_front #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [23:0]       req_in_pixel,
   input  logic              csr_fire,
   input  logic [1:0]        radius,
   input  logic [10:0]       frame_width,
   input  logic [10:0]       frame_height,
   input  logic              q_full,
   output logic              q_push,
   output gblur_pkg::cmd_type q_cmd
);
   import gblur_pkg::*;

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int P_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

   logic [WW-1:0]     w_eff;
   logic [HW-1:0]     h_eff;
   logic [RAD_W-1:0]  r_eff;
   logic [SLOT_W-1:0] rr;

   logic [TOT_W-1:0]  total_ff;
   logic [P_W-1:0]    lag_ff;
   logic              hold_ff;

   logic [P_W-1:0]    p_ff, p_in;
   logic [TOT_W-1:0]  n_ff, n_in;
   logic [XW-1:0]     qx_ff, qx_in, nx_ff, nx_in;
   logic [YW-1:0]     ny_ff, ny_in;
   logic [SLOT_W-1:0] qslot_ff, qslot_in, nslot_ff, nslot_in;

   logic [P_W-1:0]    q_lin;
   logic              p_ge_r, have_q, emit, ignore, last, take;
   logic [31:0]       rd_slot_sum;

   always_comb begin
      if (frame_width == '0) w_eff = WW'(1);
      else if (32'(frame_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(frame_width);
      if (frame_height == '0) h_eff = HW'(1);
      else if (32'(frame_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(frame_height);
      r_eff = (32'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius);
      rr    = SLOT_W'({r_eff, 1'b0});
   end

   // frame size and output lag, registered from the clamped configuration registers
   always_ff @(posedge clock) begin
      total_ff <= TOT_W'(TOT_W'(w_eff) * TOT_W'(h_eff));
      lag_ff   <= P_W'(P_W'(r_eff) * P_W'(w_eff) + P_W'(r_eff));
   end

   assign req_ready = !q_full && !hold_ff;

   always_comb begin
      p_ge_r = p_ff >= P_W'(r_eff);
      q_lin  = p_ff - P_W'(r_eff);
      have_q = (r_eff != '0) && p_ge_r && (q_lin < P_W'(total_ff));
      emit   = (r_eff == '0) || (p_ff >= lag_ff);
      if (r_eff == '0) ignore = req_func;
      else ignore = req_func && (p_ff < P_W'(total_ff));
      last   = emit && (({1'b0, n_ff} + (TOT_W + 1)'(1)) >= {1'b0, total_ff});
      take   = req_valid && req_ready && !ignore;
      q_push = take;

      rd_slot_sum = 32'(nslot_ff) + 32'(r_eff);
      if (rd_slot_sum >= 32'(rr)) rd_slot_sum = rd_slot_sum - 32'(rr);

      q_cmd.pass    = (r_eff == '0);
      q_cmd.zero_in = req_func || (p_ff >= P_W'(total_ff));
      q_cmd.have_q  = have_q;
      q_cmd.h_int   = (32'(qx_ff) >= 32'(r_eff)) &&
                      (32'(qx_ff) + 32'(r_eff) < 32'(w_eff));
      q_cmd.emit    = emit;
      q_cmd.v_int   = (32'(ny_ff) >= 32'(r_eff)) &&
                      (32'(ny_ff) + 32'(r_eff) < 32'(h_eff));
      q_cmd.last    = last;
      q_cmd.radius  = r_eff;
      q_cmd.wr_slot = qslot_ff;
      q_cmd.wr_x    = COL_W'(qx_ff);
      q_cmd.rd_slot = SLOT_W'(rd_slot_sum);
      q_cmd.rd_x    = COL_W'(nx_ff);
      q_cmd.pix     = req_in_pixel;
   end

   always_comb begin
      p_in     = p_ff;
      n_in     = n_ff;
      qx_in    = qx_ff;
      qslot_in = qslot_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      nslot_in = nslot_ff;
      if (take) begin
         if (last) begin
            p_in     = '0;
            n_in     = '0;
            qx_in    = '0;
            qslot_in = '0;
            nx_in    = '0;
            ny_in    = '0;
            nslot_in = '0;
         end else begin
            p_in = p_ff + P_W'(1);
            if ((r_eff != '0) && p_ge_r) begin
               if (32'(qx_ff) + 1 >= 32'(w_eff)) begin
                  qx_in    = '0;
                  qslot_in = (32'(qslot_ff) + 1 >= 32'(rr)) ? '0 : qslot_ff + SLOT_W'(1);
               end else begin
                  qx_in = qx_ff + XW'(1);
               end
            end
            if (emit) begin
               n_in = n_ff + TOT_W'(1);
               if (32'(nx_ff) + 1 >= 32'(w_eff)) begin
                  nx_in    = '0;
                  ny_in    = ny_ff + YW'(1);
                  nslot_in = (32'(nslot_ff) + 1 >= 32'(rr)) ? '0 : nslot_ff + SLOT_W'(1);
               end else begin
                  nx_in = nx_ff + XW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= 1'b0;
         p_ff     <= '0;
         n_ff     <= '0;
         qx_ff    <= '0;
         qslot_ff <= '0;
         nx_ff    <= '0;
         ny_ff    <= '0;
         nslot_ff <= '0;
      end else begin
         hold_ff  <= csr_fire;
         p_ff     <= p_in;
         n_ff     <= n_in;
         qx_ff    <= qx_in;
         qslot_ff <= qslot_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         nslot_ff <= nslot_in;
      end
   end
endmodule

FILE: rtl/gblur_back.sv
`include "assert_macros.svh"

module gblur_back #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  gblur_pkg::cmd_type     q_cmd,
   input  gblur_pkg::weights_type weights,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [23:0]            rsp_out_pixel,
   output logic                   rsp_frame_last
);
   import gblur_pkg::*;

   localparam int TAPS  = 2 * MAX_RADIUS + 1;
   localparam int VT_N  = 2 * MAX_RADIUS;
   localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int RI_W  = $clog2(TAPS);
   localparam int VI_W  = $clog2(VT_N);
   localparam int D_W   = $clog2(MAX_RADIUS + 1);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [PIX_W-1:0]  raw_ff [TAPS];
   logic [PIX_W-1:0]  raw_in [TAPS];
   logic [PIX_W-1:0]  vt_ff [VT_N];
   logic [PIX_W-1:0]  vt_in [VT_N];
   logic [PIX_W-1:0]  cur_ff, cur_in, res_ff, res_in;
   logic [ACC_W-1:0]  acc_ff [3];
   logic [ACC_W-1:0]  acc_in [3];
   logic [ACC_W-1:0]  acc_next [3];
   logic [D_W-1:0]    d_ff, d_in;
   logic [SLOT_W-1:0] rk_ff, rk_in, rslot_ff, rslot_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;

   logic [PIX_W-1:0]  a_word, b_word, mac_pix;
   logic [WGT_W-1:0]  wsel;
   logic [8:0]        pair_sum [3];
   logic [31:0]       ra, dd, rr;
   logic              single, last_tap, can_go;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [PIX_W-1:0]  ram_rdata;

   gblur_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cur_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_waddr = AW'(32'(cmd_ff.wr_slot) * MAX_WIDTH + 32'(cmd_ff.wr_x));
   assign ram_raddr = AW'(32'(rslot_ff) * MAX_WIDTH + 32'(cmd_ff.rd_x));

   // shared multiply-accumulate: one tap distance per cycle, both taps summed first
   always_comb begin
      ra       = 32'(cmd_ff.radius);
      dd       = 32'(d_ff);
      rr       = 2 * ra;
      single   = (dd == 0);
      last_tap = (dd == ra);
      if (state_ff == B_VERT) begin
         a_word = vt_ff[VI_W'(ra - dd)];
         b_word = last_tap ? cur_ff : vt_ff[VI_W'(ra + dd)];
      end else begin
         a_word = raw_ff[RI_W'(ra - dd)];
         b_word = raw_ff[RI_W'(ra + dd)];
      end
      wsel = (dd < WGT_N) ? weights[2'(d_ff)] : '0;
      for (int c = 0; c < 3; c++) begin
         pair_sum[c] = {1'b0, a_word[8*c +: 8]} + (single ? 9'd0 : {1'b0, b_word[8*c +: 8]});
         acc_next[c] = acc_ff[c] + ACC_W'(ACC_W'(pair_sum[c]) * ACC_W'(wsel));
      end
      mac_pix = {sat8(acc_next[2]), sat8(acc_next[1]), sat8(acc_next[0])};
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      raw_in       = raw_ff;
      vt_in        = vt_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      rk_in        = rk_ff;
      rslot_in     = rslot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      can_go       = !cmd_ff.emit || !rsp_valid_ff || rsp_ready;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               d_in     = '0;
               rk_in    = '0;
               rslot_in = q_cmd.rd_slot;
               for (int c = 0; c < 3; c++) acc_in[c] = '0;
               if (q_cmd.pass) begin
                  res_in   = q_cmd.pix;
                  state_in = B_DONE;
               end else begin
                  raw_in[0] = q_cmd.zero_in ? '0 : q_cmd.pix;
                  for (int i = 1; i < TAPS; i++) raw_in[i] = raw_ff[i-1];
                  if (q_cmd.have_q) state_in = B_HORZ;
                  else if (q_cmd.emit) state_in = B_READ;
                  else state_in = B_DONE;
               end
            end
         end
         B_HORZ: begin
            if (!cmd_ff.h_int) begin
               cur_in   = raw_ff[RI_W'(ra)];
               state_in = cmd_ff.emit ? B_READ : B_DONE;
            end else if (last_tap) begin
               cur_in   = mac_pix;
               d_in     = '0;
               for (int c = 0; c < 3; c++) acc_in[c] = '0;
               state_in = cmd_ff.emit ? B_READ : B_DONE;
            end else begin
               acc_in = acc_next;
               d_in   = d_ff + D_W'(1);
            end
         end
         B_READ: begin
            // one line-store row per cycle, its data lands in the next cycle
            if (32'(rk_ff) < rr) begin
               ram_re   = 1'b1;
               rslot_in = (32'(rslot_ff) + 1 >= rr) ? '0 : rslot_ff + SLOT_W'(1);
            end
            if (rk_ff != '0) vt_in[VI_W'(32'(rk_ff) - 1)] = ram_rdata;
            rk_in = rk_ff + SLOT_W'(1);
            if (32'(rk_ff) == rr) state_in = B_VERT;
         end
         B_VERT: begin
            if (!cmd_ff.v_int) begin
               res_in   = vt_ff[VI_W'(ra)];
               state_in = B_DONE;
            end else if (last_tap) begin
               res_in   = mac_pix;
               state_in = B_DONE;
            end else begin
               acc_in = acc_next;
               d_in   = d_ff + D_W'(1);
            end
         end
         B_DONE: begin
            // write-back after the reads: the oldest row shares this slot
            if (can_go) begin
               ram_we   = cmd_ff.have_q;
               state_in = B_IDLE;
               if (cmd_ff.emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_pix_in   = res_ff;
                  rsp_last_in  = cmd_ff.last;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         d_ff         <= '0;
         rk_ff        <= '0;
         for (int i = 0; i < TAPS; i++) raw_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         d_ff         <= d_in;
         rk_ff        <= rk_in;
         raw_ff       <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      vt_ff       <= vt_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
      acc_ff      <= acc_in;
      rslot_ff    <= rslot_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_pixel  = rsp_pix_ff;
   assign rsp_frame_last = rsp_last_ff;

   `AST_IMPLIES(a_read_bound, clock, reset, state_ff == B_READ, 32'(rk_ff) <= 2 * 32'(cmd_ff.radius), "line store read count overran")
   `AST_IMPLIES(a_tap_bound, clock, reset, (state_ff == B_HORZ) || (state_ff == B_VERT), 32'(d_ff) <= 32'(cmd_ff.radius), "tap distance past radius")
   `AST_IMPLIES(a_write_src, clock, reset, ram_we, cmd_ff.have_q && !cmd_ff.pass, "line store written without a column result")
   `AST_NEXT(a_pop_starts, clock, reset, q_pop, state_ff != B_IDLE, "popped word not taken up")
endmodule

FILE: rtl/separable_gaussian_blur_rgb_core.sv
// Separable Gaussian blur on RGB words in raster order. A shared multiply-accumulate
// handles one tap distance per cycle in a horizontal and then a vertical pass on interior
// pixels, and the single read port of the line store fetches one of 2*radius stored rows
// per cycle. A queue between the classifier and the datapath lets the input keep taking
// words while a result waits. The output pixel lags its input by radius*frame_width+radius
// words; after the last input pixel, send flush words (req_func=1) to drain the tail,
// which ends with rsp_frame_last. Each register write holds the input off in the cycle
// after it. The line store needs no clearing pass.
module separable_gaussian_blur_rgb_core #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [23:0] req_in_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_out_pixel,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);
   import gblur_pkg::*;

   logic [1:0]  radius_ff;
   logic [10:0] width_ff, height_ff;
   weights_type weight_ff;
   logic        csr_fire;

   logic        q_push, q_pop, q_full, q_empty;
   cmd_type     push_cmd, pop_cmd;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 2'd1;
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
         weight_ff <= {17'd0, 17'd0, 17'd0, 17'd65536};
      end else if (csr_fire) begin
         case (csr_index)
            CSR_RADIUS:   radius_ff    <= csr_data[1:0];
            CSR_WIDTH:    width_ff     <= csr_data[10:0];
            CSR_HEIGHT:   height_ff    <= csr_data[10:0];
            CSR_W_CENTER: weight_ff[0] <= csr_data;
            CSR_W_OFF1:   weight_ff[1] <= csr_data;
            CSR_W_OFF2:   weight_ff[2] <= csr_data;
            CSR_W_OFF3:   weight_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   gblur_front #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_in_pixel (req_in_pixel),
      .csr_fire     (csr_fire),
      .radius       (radius_ff),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   gblur_queue #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .pop       (q_pop),
      .pop_data  (pop_cmd),
      .full      (q_full),
      .empty     (q_empty)
   );

   gblur_back #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_cmd          (pop_cmd),
      .weights        (weight_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_last (rsp_frame_last)
   );
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import gblur_pkg::*;

   typedef struct {
      logic [23:0] pixel;
      logic        last;
   } blur_out_type;

   class blur_scoreboard;
      logic [1:0]  radius;
      logic [10:0] frame_w;
      logic [10:0] frame_h;
      logic [16:0] wgt[4];
      logic [23:0] line_mem[6144];
      logic [23:0] raw_taps[7];
      longint      col, row, out_idx;
      blur_out_type pending[$];
      int          errors;

      function new();
         radius = 2'd1;
         frame_w = 11'd1024;
         frame_h = 11'd1024;
         wgt[0] = 17'd65536;
         wgt[1] = '0;
         wgt[2] = '0;
         wgt[3] = '0;
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (raw_taps[i]) raw_taps[i] = '0;
         col = 0;
         row = 0;
         out_idx = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [16:0] data);
         case (idx)
            CSR_RADIUS:   radius = data[1:0];
            CSR_WIDTH:    frame_w = data[10:0];
            CSR_HEIGHT:   frame_h = data[10:0];
            CSR_W_CENTER: wgt[0] = data;
            CSR_W_OFF1:   wgt[1] = data;
            CSR_W_OFF2:   wgt[2] = data;
            CSR_W_OFF3:   wgt[3] = data;
            default: ;
         endcase
      endfunction

      // per channel: sum of weight*value, >>16, clamp to 255
      function logic [23:0] weigh_taps(logic [23:0] taps[7], int r);
         logic [23:0] res;
         longint      acc;
         int          d;
         res = '0;
         for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int k = 0; k <= 2 * r; k++) begin
               d = (k < r) ? (r - k) : (k - r);
               acc += longint'(wgt[d]) * longint'(taps[k][ch*8 +: 8]);
            end
            acc = acc >> 16;
            if (acc > 255) acc = 255;
            res[ch*8 +: 8] = acc[7:0];
         end
         return res;
      endfunction

      function void note_input(logic func, logic [23:0] pix);
         int          r;
         int          rr;
         longint      w, h, total, p, q, lag, n, y, x, qx;
         logic        have_q, emit, last;
         logic [23:0] cur, result;
         logic [23:0] taps[7];
         r = radius;
         rr = 2 * r;
         w = frame_w;
         h = frame_h;
         if (w < 1) w = 1;
         if (w > 1024) w = 1024;
         if (h < 1) h = 1;
         if (h > 1024) h = 1024;
         total = w * h;
         p = row * w + col;
         cur = '0;
         result = '0;
         n = 0;
         foreach (taps[i]) taps[i] = '0;
         if (r == 0) begin
            if (func) return;
            n = out_idx;
            result = pix;
            emit = 1'b1;
         end else begin
            if (func && p < total) return;
            for (int k = 6; k > 0; k--) raw_taps[k] = raw_taps[k-1];
            raw_taps[0] = (!func && p < total) ? pix : 24'd0;
            have_q = (p >= r);
            q = have_q ? p - r : 0;
            have_q = have_q && (q < total);
            if (have_q) begin
               qx = q % w;
               if (qx >= r && qx + r < w) begin
                  for (int k = 0; k <= rr; k++) taps[k] = raw_taps[rr-k];
                  cur = weigh_taps(taps, r);
               end else begin
                  cur = raw_taps[r];
               end
            end
            lag = r * w + r;
            emit = (p >= lag);
            if (emit) begin
               n = out_idx;
               y = n / w;
               x = n % w;
               if (y >= r && y + r < h) begin
                  for (int k = 0; k < rr; k++)
                     taps[k] = line_mem[((y - r + k) % rr) * 1024 + x];
                  taps[rr] = cur;
                  result = weigh_taps(taps, r);
               end else begin
                  result = line_mem[(y % rr) * 1024 + x];
               end
            end
            if (have_q) line_mem[((q / w) % rr) * 1024 + (q % w)] = cur;
         end
         col++;
         if (col >= w) begin
            col = 0;
            row++;
         end
         if (!emit) return;
         last = (n + 1 >= total);
         pending.push_back('{pixel: result, last: last});
         if (last) begin
            col = 0;
            row = 0;
            out_idx = 0;
         end else begin
            out_idx++;
         end
      endfunction

      function void report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endfunction

      function void check_result(logic [23:0] pix, logic last);
         blur_out_type exp_word;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word pixel %h last %b", pix, last));
            return;
         end
         exp_word = pending.pop_front();
         if (pix !== exp_word.pixel)
            report($sformatf("out_pixel %h, want %h", pix, exp_word.pixel));
         if (last !== exp_word.last)
            report($sformatf("frame_last %b, want %b", last, exp_word.last));
      endfunction
   endclass

   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [23:0] req_in_pixel = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_out_pixel;
   logic        rsp_frame_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_data = '0;

   blur_scoreboard blur_sb = new();

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off_cycles = 0;
   int  idle_count = 0;
   int  words_sent = 0;
   int  cfg_radius, cfg_w, cfg_h;

   separable_gaussian_blur_rgb_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_in_pixel(req_in_pixel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_pixel(rsp_out_pixel),
      .rsp_frame_last(rsp_frame_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // monitors and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) blur_sb.check_result(rsp_out_pixel, rsp_frame_last);
         if (req_valid && req_ready) blur_sb.note_input(req_func, req_in_pixel);
         if (csr_valid && csr_ready) blur_sb.write_reg(csr_index, csr_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            idle_count = 0;
         else
            idle_count++;
         if (idle_count >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_word(logic func, logic [23:0] pix);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_in_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int r, int w, int h, int wc, int w1, int w2, int w3);
      write_csr(CSR_RADIUS, 17'(r));
      write_csr(CSR_WIDTH, 17'(w));
      write_csr(CSR_HEIGHT, 17'(h));
      write_csr(CSR_W_CENTER, 17'(wc));
      write_csr(CSR_W_OFF1, 17'(w1));
      write_csr(CSR_W_OFF2, 17'(w2));
      write_csr(CSR_W_OFF3, 17'(w3));
      cfg_radius = r;
      cfg_w = (w < 1) ? 1 : ((w > 1024) ? 1024 : w);
      cfg_h = (h < 1) ? 1 : ((h > 1024) ? 1024 : h);
   endtask

   function automatic logic [23:0] pick_pixel();
      case ($urandom_range(7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // one full frame: pixels with optional early flush words, then the drain
   task automatic run_frame(int flush_noise_pct);
      int total;
      int lag;
      total = cfg_w * cfg_h;
      lag = (cfg_radius == 0) ? 0 : cfg_radius * cfg_w + cfg_radius;
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(99) < flush_noise_pct) send_word(1'b1, 24'($urandom));
         send_word(1'b0, pick_pixel());
      end
      for (int i = 0; i < lag; i++) begin
         // a pixel during the drain acts as a flush word
         if ($urandom_range(7) == 0) send_word(1'b0, 24'($urandom));
         else send_word(1'b1, 24'($urandom));
      end
      req_valid <= 1'b0;
      while (blur_sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic int rand_weight();
      case ($urandom_range(5))
         0: return 0;
         1: return 65536;
         2: return 131071;
         3: return $urandom_range(131071);
         default: return $urandom_range(40000);
      endcase
   endfunction

   initial begin
      int w, h;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames
      configure(1, 3, 3, 32768, 16384, 0, 0);
      run_frame(30);
      configure(0, 4, 2, 0, 0, 0, 0);
      run_frame(40);
      configure(3, 2, 2, 65536, 65536, 65536, 65536);
      run_frame(10);
      configure(2, 5, 5, 131071, 0, 131071, 0);
      run_frame(10);
      configure(3, 7, 7, 20000, 15000, 6000, 1500);
      run_frame(10);
      // width above the limit clamps to a full row
      configure(0, 2047, 1, 65536, 0, 0, 0);
      run_frame(0);

      // random frames over the idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         words_sent = 0;
         while (words_sent < 150) begin
            w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 16);
            h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
            configure($urandom_range(3), w, h, rand_weight(), rand_weight(),
                      rand_weight(), rand_weight());
            if (phase == 0 && words_sent == 0) hold_off_cycles = 600;
            run_frame(5);
         end
      end

      while (blur_sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (blur_sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
